// ===== rtl/core/zcpc_pkg.sv =====
// Shared constants, types and register layout for the zero-cross pitch-to-CV block.
`timescale 1ns / 1ps
`default_nettype none

package zcpc_pkg;

   localparam int SAMPLE_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF   = 16;
   localparam int CV_FRAC_BITS_DEF = 12;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int CV_OUT_W    = 16;
   localparam int SLEW_COEF_W = 16;
   localparam int SLEW_SHIFT  = 16;
   localparam int CV_VOLTS    = 5;

   // log2 mantissa is Q1.30
   localparam int X_W    = 31;
   localparam int X_FRAC = 30;
   localparam int SH_W   = 5;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOG_REF_OFFSET   = 3'd0,
      CSR_CROSS_HYSTERESIS = 3'd1,
      CSR_AMP_THRESHOLD    = 3'd2,
      CSR_PERIOD_LO        = 3'd3,
      CSR_PERIOD_HI        = 3'd4,
      CSR_CHANGE_THRESHOLD = 3'd5,
      CSR_SLEW_COEF        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [15:0] log_ref_offset;
      logic [14:0] cross_hysteresis;
      logic [14:0] amp_threshold;
      logic [15:0] period_lo;
      logic [15:0] period_hi;
      logic [11:0] change_threshold;
      logic [15:0] slew_coef;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      log_ref_offset:   16'd27727,
      cross_hysteresis: 15'd33,
      amp_threshold:    15'd328,
      period_lo:        16'd3,
      period_hi:        16'd2400,
      change_threshold: 12'd41,
      slew_coef:        16'd66
   };

   typedef struct packed {
      logic gate;
      logic crossed;
      logic in_range;
   } side_type;

   typedef struct packed {
      logic signed [CV_OUT_W-1:0] cv_out;
      logic                       gate_out;
      logic                       crossing_seen;
   } res_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/zcpc_ifs.sv =====
// Valid/ready stream interfaces for the sample and CV channels.
`timescale 1ns / 1ps
`default_nettype none

interface zcpc_req_if import zcpc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          gate_in;

   modport source (output valid, output sample, output gate_in, input ready);
   modport sink   (input valid, input sample, input gate_in, output ready);
endinterface

interface zcpc_rsp_if import zcpc_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [CV_OUT_W-1:0] cv_out;
   logic                       gate_out;
   logic                       crossing_seen;

   modport source (output valid, output cv_out, output gate_out, output crossing_seen,
                   input ready);
   modport sink   (input valid, input cv_out, input gate_out, input crossing_seen,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/zcpc_front.sv =====
// Front stage: rising zero-crossing detect and period counter.
`timescale 1ns / 1ps
`default_nettype none

module zcpc_front import zcpc_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  wire logic                          take,
   input  wire logic signed [SAMPLE_BITS-1:0] sample,
   input  wire logic                          gate_in,
   input  wire cfg_type                       cfg,
   output logic                               out_valid,
   output logic [COUNT_BITS-1:0]              period,
   output side_type                           side
);

   localparam int CMP_W = max_int(SAMPLE_BITS, 16) + 1;
   localparam int PC_W  = max_int(COUNT_BITS, 16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic signed [SAMPLE_BITS-1:0] prev_sample_ff;
   logic [COUNT_BITS-1:0]         period_count_ff;
   logic                          valid_ff;
   logic [COUNT_BITS-1:0]         period_ff;
   side_type                      side_ff;

   logic [COUNT_BITS-1:0]         count_inc;
   logic signed [CMP_W-1:0]       prev_ext;
   logic signed [CMP_W-1:0]       cur_ext;
   logic signed [CMP_W-1:0]       hyst_ext;
   logic signed [CMP_W-1:0]       amp_ext;
   logic                          crossed;
   logic [PC_W-1:0]               period_w;
   logic                          in_range;
   side_type                      side_in;

   always_comb begin
      count_inc = (period_count_ff < COUNT_MAX) ? period_count_ff + 1'b1 : period_count_ff;
      prev_ext  = CMP_W'(prev_sample_ff);
      cur_ext   = CMP_W'(sample);
      hyst_ext  = $signed(CMP_W'(cfg.cross_hysteresis));
      amp_ext   = $signed(CMP_W'(cfg.amp_threshold));
      crossed   = (prev_ext <= -hyst_ext) && (cur_ext >= hyst_ext) && (cur_ext > amp_ext);
      period_w  = PC_W'(count_inc);
      in_range  = (period_w >= PC_W'(cfg.period_lo)) && (period_w <= PC_W'(cfg.period_hi));
      side_in.gate     = gate_in;
      side_in.crossed  = crossed;
      side_in.in_range = in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff  <= '0;
         period_count_ff <= '0;
         valid_ff        <= 1'b0;
      end else begin
         if (en) begin
            valid_ff <= take;
         end
         if (take) begin
            prev_sample_ff  <= sample;
            period_count_ff <= crossed ? '0 : count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         period_ff <= count_inc;
         side_ff   <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign period    = period_ff;
   assign side      = side_ff;

endmodule

`default_nettype wire

// ===== rtl/core/zcpc_log2_pipe.sv =====
// Pipelined fixed-point log2 of the period: normalize, then one squaring per stage.
`timescale 1ns / 1ps
`default_nettype none

module zcpc_log2_pipe import zcpc_pkg::*; #(
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int CV_FRAC_BITS = CV_FRAC_BITS_DEF,
   parameter int LOG_W        = $clog2(COUNT_BITS) + CV_FRAC_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_valid,
   input  wire logic [COUNT_BITS-1:0] period,
   input  wire side_type              side,
   output logic                       out_valid,
   output logic [LOG_W-1:0]           log_val,
   output side_type                   side_out
);

   localparam int EW = $clog2(COUNT_BITS);
   localparam int F  = CV_FRAC_BITS;

   logic                 valid_ff [0:F];
   logic [X_W-1:0]       x_ff     [0:F];
   logic [EW-1:0]        e_ff     [0:F];
   logic [F-1:0]         frac_ff  [0:F];
   side_type             side_ff  [0:F];

   logic [EW-1:0]        lead;
   logic [SH_W-1:0]      sh;
   logic [X_W-1:0]       x0_in;

   // leading one gives the integer part; mantissa lands in Q1.30
   always_comb begin
      lead = '0;
      for (int i = 0; i < COUNT_BITS; i++) begin
         if (period[i]) begin
            lead = EW'(i);
         end
      end
      sh    = SH_W'(X_FRAC) - SH_W'(lead);
      x0_in = X_W'(period) << sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         e_ff[0]    <= lead;
         frac_ff[0] <= '0;
         side_ff[0] <= side;
      end
   end

   for (genvar k = 1; k <= F; k++) begin : gen_sq
      logic [2*X_W-1:0] sq;
      logic [X_W:0]     t;
      logic [X_W-1:0]   x_in;
      logic [F-1:0]     frac_in;

      assign sq      = (2*X_W)'(x_ff[k-1]) * (2*X_W)'(x_ff[k-1]);
      assign t       = sq[2*X_W-1:X_FRAC];
      assign x_in    = t[X_W] ? t[X_W:1] : t[X_W-1:0];
      assign frac_in = frac_ff[k-1] | (F'(t[X_W]) << (F - k));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            e_ff[k]    <= e_ff[k-1];
            frac_ff[k] <= frac_in;
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[F];
   assign log_val   = LOG_W'({e_ff[F], frac_ff[F]});
   assign side_out  = side_ff[F];

endmodule

`default_nettype wire

// ===== rtl/core/zcpc_slew.sv =====
// Target CV from log2, change gate, and one-pole slew of the output CV.
`timescale 1ns / 1ps
`default_nettype none

module zcpc_slew import zcpc_pkg::*; #(
   parameter int CV_FRAC_BITS = CV_FRAC_BITS_DEF,
   parameter int LOG_W        = 4 + CV_FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             en,
   input  wire logic             in_valid,
   input  wire logic [LOG_W-1:0] log_val,
   input  wire side_type         side,
   input  wire cfg_type          cfg,
   output logic                  res_valid,
   output res_type               res
);

   localparam int F      = CV_FRAC_BITS;
   localparam int CV_W   = F + 4;
   localparam int SM_W   = CV_W + SLEW_SHIFT;
   localparam int DIFF_W = SM_W + 1;
   localparam int PROD_W = DIFF_W + SLEW_COEF_W + 1;
   localparam int NT_W   = max_int(16, LOG_W) + 1;
   localparam int D_W    = CV_W + 1;
   localparam int WIDE   = max_int(CV_W, CV_OUT_W);
   localparam int CV_LIM = CV_VOLTS << F;
   localparam logic signed [NT_W-1:0] NT_LIM = NT_W'(CV_LIM);
   localparam logic signed [CV_W-1:0] CV_MAX = CV_W'(CV_LIM);

   logic                     a_valid_ff;
   logic signed [CV_W-1:0]   ntc_ff;
   side_type                 side_a_ff;
   logic signed [CV_W-1:0]   target_ff;
   logic signed [SM_W-1:0]   smoothed_ff;

   logic signed [NT_W-1:0]   nt;
   logic signed [NT_W-1:0]   nt_c;
   logic signed [CV_W-1:0]   ntc_in;
   logic signed [D_W-1:0]    d;
   logic [D_W-1:0]           d_abs;
   logic                     upd;
   logic signed [CV_W-1:0]   target_in;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] step;
   logic signed [DIFF_W-1:0] sum;
   logic signed [SM_W-1:0]   smoothed_in;
   logic signed [CV_W-1:0]   cv;
   logic signed [CV_W-1:0]   cv_c;
   logic signed [WIDE-1:0]   cv_wide;

   always_comb begin
      nt = $signed(NT_W'(cfg.log_ref_offset)) - $signed(NT_W'(log_val));
      if (nt > NT_LIM) begin
         nt_c = NT_LIM;
      end else if (nt < -NT_LIM) begin
         nt_c = -NT_LIM;
      end else begin
         nt_c = nt;
      end
      ntc_in = $signed(nt_c[CV_W-1:0]);
   end

   always_comb begin
      d         = D_W'(ntc_ff) - D_W'(target_ff);
      d_abs     = d[D_W-1] ? -d : d;
      upd       = side_a_ff.crossed && side_a_ff.in_range &&
                  (d_abs > D_W'(cfg.change_threshold));
      target_in = upd ? ntc_ff : target_ff;
      diff      = DIFF_W'($signed({target_in, {SLEW_SHIFT{1'b0}}})) - DIFF_W'(smoothed_ff);
      prod      = PROD_W'(diff) * $signed(PROD_W'(cfg.slew_coef));
      step      = prod >>> SLEW_SHIFT;
      sum       = DIFF_W'(smoothed_ff) + $signed(step[DIFF_W-1:0]);
      smoothed_in = $signed(sum[SM_W-1:0]);
      cv        = $signed(smoothed_in[SM_W-1:SLEW_SHIFT]);
      if (cv > CV_MAX) begin
         cv_c = CV_MAX;
      end else if (cv < -CV_MAX) begin
         cv_c = -CV_MAX;
      end else begin
         cv_c = cv;
      end
      cv_wide = WIDE'(cv_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         target_ff   <= '0;
         smoothed_ff <= '0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         if (a_valid_ff) begin
            target_ff   <= target_in;
            smoothed_ff <= smoothed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ntc_ff    <= ntc_in;
         side_a_ff <= side;
      end
   end

   assign res_valid         = a_valid_ff;
   assign res.cv_out        = cv_wide[CV_OUT_W-1:0];
   assign res.gate_out      = side_a_ff.gate;
   assign res.crossing_seen = side_a_ff.crossed;

endmodule

`default_nettype wire

// ===== rtl/core/zero_cross_pitch_to_cv.sv =====
// Top level: zero-cross pitch detector to volt-per-octave CV with output skid.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        sample, gate_in
//   rsp      out  valid/ready        cv_out, gate_out, crossing_seen
//   csr      in   csr_wen            csr_index, csr_wdata
//
// One item per cycle sustained while the skid is empty.
// Most of the depth is the log2 pipeline, one 31x31 mantissa squaring per stage.
// Target and slew state close their loop through one register and a single slew multiply.
// A stalled rsp fills a one-entry skid; while it is full the pipeline holds.
// Reset clears valids, detector state, target and slew; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module zero_cross_pitch_to_cv import zcpc_pkg::*; #(
   parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS   = COUNT_BITS_DEF,
   parameter int CV_FRAC_BITS = CV_FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   zcpc_req_if.sink                    req,
   zcpc_rsp_if.source                  rsp,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int LOG_W = $clog2(COUNT_BITS) + CV_FRAC_BITS;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;

   logic                   en;
   logic                   take;
   logic                   f_valid;
   logic [COUNT_BITS-1:0]  f_period;
   side_type               f_side;
   logic                   l_valid;
   logic [LOG_W-1:0]       l_val;
   side_type               l_side;
   logic                   res_valid;
   res_type                res;

   res_type                out_ff;
   res_type                out_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   res_type                skid_ff;
   res_type                skid_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   logic                   emit;
   logic                   take_out;

   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index)
         CSR_LOG_REF_OFFSET:   cfg_in.log_ref_offset   = csr_wdata[15:0];
         CSR_CROSS_HYSTERESIS: cfg_in.cross_hysteresis = csr_wdata[14:0];
         CSR_AMP_THRESHOLD:    cfg_in.amp_threshold    = csr_wdata[14:0];
         CSR_PERIOD_LO:        cfg_in.period_lo        = csr_wdata[15:0];
         CSR_PERIOD_HI:        cfg_in.period_hi        = csr_wdata[15:0];
         CSR_CHANGE_THRESHOLD: cfg_in.change_threshold = csr_wdata[11:0];
         CSR_SLEW_COEF:        cfg_in.slew_coef        = csr_wdata[15:0];
         default:              cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_wen) begin
         cfg_ff <= cfg_in;
      end
   end

   assign en        = !skid_valid_ff;
   assign take      = req.valid && en;
   assign req.ready = en;

   zcpc_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .take      (take),
      .sample    (req.sample),
      .gate_in   (req.gate_in),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .period    (f_period),
      .side      (f_side)
   );

   zcpc_log2_pipe #(
      .COUNT_BITS   (COUNT_BITS),
      .CV_FRAC_BITS (CV_FRAC_BITS),
      .LOG_W        (LOG_W)
   ) u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .period    (f_period),
      .side      (f_side),
      .out_valid (l_valid),
      .log_val   (l_val),
      .side_out  (l_side)
   );

   zcpc_slew #(
      .CV_FRAC_BITS (CV_FRAC_BITS),
      .LOG_W        (LOG_W)
   ) u_slew (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (l_valid),
      .log_val   (l_val),
      .side      (l_side),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   assign emit     = en && res_valid;
   assign take_out = out_valid_ff && rsp.ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (take_out) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff || take_out) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (take_out) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.cv_out        = out_ff.cv_out;
   assign rsp.gate_out      = out_ff.gate_out;
   assign rsp.crossing_seen = out_ff.crossing_seen;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (emit && out_valid_ff && !rsp.ready) |=> skid_valid_ff)
      else $error("item emitted into a stalled output was dropped");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp.ready) |=> (!skid_valid_ff && out_valid_ff))
      else $error("skid did not move to the output register");

endmodule

`default_nettype wire
